### design/nfa_sim_pkg.sv
package nfa_sim_pkg;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_TEXT   = 2'd2;
	localparam logic [1:0] OP_FINISH = 2'd3;

	localparam logic [1:0] KIND_LITERAL  = 2'd0;
	localparam logic [1:0] KIND_SPLIT    = 2'd1;
	localparam logic [1:0] KIND_WILDCARD = 2'd2;
	localparam logic [1:0] KIND_ACCEPT   = 2'd3;

	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 8;

	typedef struct packed {
		logic       present;
		logic [5:0] target;
	} link_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] chr;
		link_t      first;
		link_t      second;
	} entry_t;

endpackage

### design/nfa_regex_simulator.sv
// Load writes one table entry. Start seeds the start state and walks its split closure.
// Text byte scans every entry for active states whose move matches, adding each new state
// with its closure as for start; the single table read port paces the walk.
// Finish checks the active entries for an accept state; one item in flight, result in m_tdata.
// arst_n clears the active set and control; table contents are unknown until loaded.
module nfa_regex_simulator
	import nfa_sim_pkg::*;
#(
	parameter int NUM_STATES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// entry_index, entry_kind, entry_char, first_target, first_present,
	// second_target, second_present, start_index, text_char, zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	// op
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// matched, zero pad
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int AW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int IW = AW + 1;
	localparam int EW = $bits(entry_t);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_CLOS_POP = 4'd1;
	localparam logic [3:0] ST_CLOS_RD  = 4'd2;
	localparam logic [3:0] ST_CLOS_L1  = 4'd3;
	localparam logic [3:0] ST_CLOS_L2  = 4'd4;
	localparam logic [3:0] ST_SCAN     = 4'd5;
	localparam logic [3:0] ST_SCAN_CHK = 4'd6;
	localparam logic [3:0] ST_FIN_SCAN = 4'd7;
	localparam logic [3:0] ST_FIN_CHK  = 4'd8;
	localparam logic [3:0] ST_OUT      = 4'd9;
	localparam logic [3:0] ST_COMMIT   = 4'd10;

	logic [1:0] in_op;
	logic [5:0] in_entry_index, in_first_target, in_second_target, in_start_index;
	logic [1:0] in_entry_kind;
	logic [7:0] in_entry_char, in_text_char;
	logic       in_first_present, in_second_present;

	assign in_op             = s_tuser[1:0];
	assign in_entry_index    = s_tdata[5:0];
	assign in_entry_kind     = s_tdata[7:6];
	assign in_entry_char     = s_tdata[15:8];
	assign in_first_target   = s_tdata[21:16];
	assign in_first_present  = s_tdata[22];
	assign in_second_target  = s_tdata[28:23];
	assign in_second_present = s_tdata[29];
	assign in_start_index    = s_tdata[35:30];
	assign in_text_char      = s_tdata[43:36];

	logic [3:0]            state_q;
	logic [NUM_STATES-1:0] active_q, next_q;
	logic [IW-1:0]         idx_q, sp_q;
	logic [AW-1:0]         cur_q;
	logic [7:0]            char_q;
	logic                  text_mode_q;
	logic                  match_q;
	logic                  m_tvalid_q, matched_q;

	logic          in_accept;
	entry_t        tbl_wr_entry, tbl_rd_entry;
	logic [EW-1:0] tbl_rd_data;
	logic          tbl_wr_en;
	logic [AW-1:0] tbl_rd_addr;
	logic          stk_wr_en;
	logic [AW-1:0] stk_wr_data, stk_rd_addr, stk_rd_data;

	logic          l1_ok, l2_ok, step_hit;
	logic [AW-1:0] l1_idx, l2_idx, scan_idx;

	assign in_accept = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);

	assign tbl_wr_entry = '{kind: in_entry_kind, chr: in_entry_char,
		first: '{present: in_first_present, target: in_first_target},
		second: '{present: in_second_present, target: in_second_target}};
	assign tbl_wr_en = in_accept && (in_op == OP_LOAD) &&
		(32'(in_entry_index) < NUM_STATES);
	assign tbl_rd_entry = entry_t'(tbl_rd_data);

	assign scan_idx = idx_q[AW-1:0];
	assign l1_idx   = AW'(tbl_rd_entry.first.target);
	assign l2_idx   = AW'(tbl_rd_entry.second.target);
	assign l1_ok    = tbl_rd_entry.first.present &&
		(32'(tbl_rd_entry.first.target) < NUM_STATES) && !next_q[l1_idx];
	assign l2_ok    = tbl_rd_entry.second.present &&
		(32'(tbl_rd_entry.second.target) < NUM_STATES) && !next_q[l2_idx];
	assign step_hit = (tbl_rd_entry.kind == KIND_WILDCARD ||
		(tbl_rd_entry.kind == KIND_LITERAL && tbl_rd_entry.chr == char_q)) && l1_ok;

	always_comb begin
		tbl_rd_addr = scan_idx;
		stk_wr_en   = 1'b0;
		stk_wr_data = l1_idx;
		stk_rd_addr = AW'(sp_q - IW'(1));
		unique case (state_q)
			ST_CLOS_RD: begin
				tbl_rd_addr = stk_rd_data;
			end
			ST_CLOS_L1: begin
				tbl_rd_addr = cur_q;
				stk_wr_en   = (tbl_rd_entry.kind == KIND_SPLIT) && l1_ok;
			end
			ST_CLOS_L2: begin
				stk_wr_en   = l2_ok;
				stk_wr_data = l2_idx;
			end
			ST_SCAN_CHK: begin
				stk_wr_en = step_hit;
			end
			ST_IDLE: begin
				stk_wr_data = AW'(in_start_index);
				stk_wr_en   = in_accept && (in_op == OP_START) &&
					(32'(in_start_index) < NUM_STATES);
			end
			default: begin
			end
		endcase
	end

	nfa_sim_ram #(.DEPTH(NUM_STATES), .WIDTH(EW)) u_table (
		.clk     (clk),
		.wr_en   (tbl_wr_en),
		.wr_addr (AW'(in_entry_index)),
		.wr_data (tbl_wr_entry),
		.rd_addr (tbl_rd_addr),
		.rd_data (tbl_rd_data)
	);

	nfa_sim_ram #(.DEPTH(NUM_STATES), .WIDTH(AW)) u_stack (
		.clk     (clk),
		.wr_en   (stk_wr_en),
		.wr_addr (sp_q[AW-1:0]),
		.wr_data (stk_wr_data),
		.rd_addr (stk_rd_addr),
		.rd_data (stk_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= '0;
			next_q      <= '0;
			idx_q       <= '0;
			sp_q        <= '0;
			cur_q       <= '0;
			char_q      <= '0;
			text_mode_q <= 1'b0;
			match_q     <= 1'b0;
			m_tvalid_q  <= 1'b0;
			matched_q   <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			if (stk_wr_en && (state_q != ST_IDLE)) begin
				next_q[stk_wr_data] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						idx_q   <= '0;
						match_q <= 1'b0;
						char_q  <= in_text_char;
						unique case (in_op)
							OP_START: begin
								next_q      <= stk_wr_en ?
									(NUM_STATES'(1) << stk_wr_data) : '0;
								sp_q        <= stk_wr_en ? IW'(1) : '0;
								text_mode_q <= 1'b0;
								state_q     <= ST_CLOS_POP;
							end
							OP_TEXT: begin
								next_q      <= '0;
								sp_q        <= '0;
								text_mode_q <= 1'b1;
								state_q     <= ST_SCAN;
							end
							OP_FINISH: begin
								state_q <= ST_FIN_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CLOS_POP: begin
					if (sp_q == '0) begin
						state_q <= text_mode_q ? ST_SCAN : ST_COMMIT;
					end else begin
						sp_q    <= sp_q - IW'(1);
						state_q <= ST_CLOS_RD;
					end
				end
				ST_CLOS_RD: begin
					cur_q   <= stk_rd_data;
					state_q <= ST_CLOS_L1;
				end
				ST_CLOS_L1: begin
					if (stk_wr_en) begin
						sp_q <= sp_q + IW'(1);
					end
					state_q <= (tbl_rd_entry.kind == KIND_SPLIT) ? ST_CLOS_L2 : ST_CLOS_POP;
				end
				ST_CLOS_L2: begin
					if (stk_wr_en) begin
						sp_q <= sp_q + IW'(1);
					end
					state_q <= ST_CLOS_POP;
				end
				ST_SCAN: begin
					if (idx_q == IW'(NUM_STATES)) begin
						state_q <= ST_COMMIT;
					end else if (active_q[scan_idx]) begin
						state_q <= ST_SCAN_CHK;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_SCAN_CHK: begin
					idx_q <= idx_q + IW'(1);
					if (stk_wr_en) begin
						sp_q    <= sp_q + IW'(1);
						state_q <= ST_CLOS_POP;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_FIN_SCAN: begin
					if (idx_q == IW'(NUM_STATES)) begin
						state_q <= ST_OUT;
					end else if (active_q[scan_idx]) begin
						state_q <= ST_FIN_CHK;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_FIN_CHK: begin
					if (tbl_rd_entry.kind == KIND_ACCEPT) begin
						match_q <= 1'b1;
					end
					idx_q   <= idx_q + IW'(1);
					state_q <= ST_FIN_SCAN;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						matched_q  <= match_q;
						state_q    <= ST_IDLE;
					end
				end
				ST_COMMIT: begin
					active_q <= next_q;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, matched_q};

endmodule

### design/nfa_sim_ram.sv
module nfa_sim_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import nfa_sim_pkg::*;

	localparam int NSTATES     = 64;
	localparam int ITEM_TARGET = 1985;
	localparam int PHASE2_AT   = 650;
	localparam int PHASE3_AT   = 1300;
	localparam int HOLD_CYCLES = 800;
	localparam int TAIL_CYCLES = 600;
	localparam int STALL_LIMIT = 5000;

	// one input transaction, unpacked to its fields
	typedef struct packed {
		logic [1:0] op;
		logic [5:0] idx;
		logic [1:0] kind;
		logic [7:0] chr;
		logic [5:0] t1;
		logic       p1;
		logic [5:0] t2;
		logic       p2;
		logic [5:0] start;
		logic [7:0] text;
	} nfa_item_t;

	typedef struct packed {
		nfa_item_t item;
		logic      typed;
		logic      want;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	nfa_regex_simulator #(
		.NUM_STATES(NSTATES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #1 clk = ~clk;

	// shadow of the state table and the active set
	logic [1:0]         kind_mem [NSTATES];
	logic [7:0]         chr_mem [NSTATES];
	link_t              first_mem [NSTATES];
	link_t              second_mem [NSTATES];
	logic [NSTATES-1:0] live_set;

	logic     pending_matches [$];
	int       mismatches  = 0;
	int       items_sent  = 0;
	int       quiet_cycles = 0;
	int       tx_idle_pct = 29;
	int       rx_idle_pct = 52;
	bit       hold_req    = 1'b0;
	bit       stim_done   = 1'b0;
	dir_row_t dir_rows [];

	function automatic logic [S_TDATA_W-1:0] pack_item(input nfa_item_t it);
		return {4'b0, it.text, it.start, it.p2, it.t2, it.p1, it.t1, it.chr, it.kind, it.idx};
	endfunction

	function automatic logic [NSTATES-1:0] split_closure(input logic [NSTATES-1:0] seed);
		logic [NSTATES-1:0] cur;
		logic [NSTATES-1:0] prev;
		cur = seed;
		do begin
			prev = cur;
			for (int i = 0; i < NSTATES; i++) begin
				if (cur[i] && kind_mem[i] == KIND_SPLIT) begin
					if (first_mem[i].present)
						cur[first_mem[i].target] = 1'b1;
					if (second_mem[i].present)
						cur[second_mem[i].target] = 1'b1;
				end
			end
		end while (cur != prev);
		return cur;
	endfunction

	// returns 1 when the transaction produces a result, with its value in hit
	function automatic bit nfa_predict(input nfa_item_t it, output logic hit);
		logic [NSTATES-1:0] moved;
		hit = 1'b0;
		moved = '0;
		case (it.op)
			OP_LOAD: begin
				kind_mem[it.idx] = it.kind;
				chr_mem[it.idx] = it.chr;
				first_mem[it.idx] = '{present: it.p1, target: it.t1};
				second_mem[it.idx] = '{present: it.p2, target: it.t2};
				return 1'b0;
			end
			OP_START: begin
				moved[it.start] = 1'b1;
				live_set = split_closure(moved);
				return 1'b0;
			end
			OP_TEXT: begin
				for (int i = 0; i < NSTATES; i++) begin
					if (live_set[i] && first_mem[i].present &&
							(kind_mem[i] == KIND_WILDCARD ||
							(kind_mem[i] == KIND_LITERAL && chr_mem[i] == it.text)))
						moved[first_mem[i].target] = 1'b1;
				end
				live_set = split_closure(moved);
				return 1'b0;
			end
			default: begin
				for (int i = 0; i < NSTATES; i++)
					if (live_set[i] && kind_mem[i] == KIND_ACCEPT)
						hit = 1'b1;
				return 1'b1;
			end
		endcase
	endfunction

	function automatic nfa_item_t rand_bits();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(nfa_item_t)-1:0];
	endfunction

	function automatic nfa_item_t ld(input logic [5:0] idx, input logic [1:0] kind,
			input logic [7:0] chr, input logic [5:0] t1, input logic p1,
			input logic [5:0] t2, input logic p2);
		nfa_item_t it;
		it = '0;
		it.op = OP_LOAD;
		it.idx = idx;
		it.kind = kind;
		it.chr = chr;
		it.t1 = t1;
		it.p1 = p1;
		it.t2 = t2;
		it.p2 = p2;
		return it;
	endfunction

	// start, text or finish; arg is the start index or the text byte
	function automatic nfa_item_t ctl(input logic [1:0] op, input logic [7:0] arg);
		nfa_item_t it;
		it = rand_bits();
		it.op = op;
		if (op == OP_START)
			it.start = arg[5:0];
		if (op == OP_TEXT)
			it.text = arg;
		return it;
	endfunction

	function automatic logic [7:0] text_byte();
		if ($urandom_range(3) != 0)
			return 8'h61 + 8'($urandom_range(3));
		return 8'($urandom_range(255));
	endfunction

	function automatic nfa_item_t rand_load(input logic [5:0] idx);
		nfa_item_t it;
		int        r;
		it = rand_bits();
		r = $urandom_range(99);
		it.op = OP_LOAD;
		it.idx = idx;
		it.kind = (r < 40) ? KIND_LITERAL : (r < 65) ? KIND_SPLIT :
			(r < 75) ? KIND_WILDCARD : KIND_ACCEPT;
		it.chr = text_byte();
		it.p1 = ($urandom_range(4) != 0);
		it.p2 = ($urandom_range(4) != 0);
		return it;
	endfunction

	task automatic note_mismatch(input string what, input logic want, input logic got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected matched=%0b, got %0b", $time, what, want, got);
	endtask

	task automatic offer(input nfa_item_t it, input logic typed, input logic want);
		logic hit;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.op;
		s_tdata <= pack_item(it);
		do begin
			@(posedge clk);
		end while (s_tready !== 1'b1);
		if (nfa_predict(it, hit))
			pending_matches.push_back(typed ? want : hit);
		items_sent++;
		if (items_sent == PHASE2_AT) begin
			tx_idle_pct = 52;
			rx_idle_pct = 29;
		end
		if (items_sent == PHASE3_AT) begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
			hold_req = 1'b1;
		end
	endtask

	initial begin
		foreach (kind_mem[i]) begin
			kind_mem[i] = KIND_LITERAL;
			chr_mem[i] = '0;
			first_mem[i] = '0;
			second_mem[i] = '0;
		end
		live_set = '0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 0: 'a' -> 1;  1: split 2 / 63;  2: any -> 1;  3: 0xFF -> 63;
		// 4: split with only its second link;  63: accept
		dir_rows = '{
			'{ctl(OP_FINISH, 8'h00), 1'b1, 1'b0},
			'{ctl(OP_TEXT, 8'hFF), 1'b0, 1'b0},
			'{ctl(OP_FINISH, 8'h00), 1'b1, 1'b0},
			'{ld(6'd63, KIND_ACCEPT, 8'h00, 6'd0, 1'b0, 6'd0, 1'b0), 1'b0, 1'b0},
			'{ld(6'd0, KIND_LITERAL, 8'h61, 6'd1, 1'b1, 6'd63, 1'b0), 1'b0, 1'b0},
			'{ld(6'd1, KIND_SPLIT, 8'hFF, 6'd2, 1'b1, 6'd63, 1'b1), 1'b0, 1'b0},
			'{ld(6'd2, KIND_WILDCARD, 8'h00, 6'd1, 1'b1, 6'd0, 1'b0), 1'b0, 1'b0},
			'{ld(6'd3, KIND_LITERAL, 8'hFF, 6'd63, 1'b1, 6'd0, 1'b1), 1'b0, 1'b0},
			'{ld(6'd4, KIND_SPLIT, 8'h00, 6'd5, 1'b0, 6'd63, 1'b1), 1'b0, 1'b0},
			'{ctl(OP_START, 8'd0), 1'b0, 1'b0},
			'{ctl(OP_FINISH, 8'h00), 1'b0, 1'b0},
			'{ctl(OP_TEXT, 8'h61), 1'b0, 1'b0},
			'{ctl(OP_FINISH, 8'h00), 1'b0, 1'b0},
			'{ctl(OP_TEXT, 8'h00), 1'b0, 1'b0},
			'{ctl(OP_FINISH, 8'h00), 1'b0, 1'b0},
			'{ctl(OP_START, 8'd4), 1'b0, 1'b0},
			'{ctl(OP_FINISH, 8'h00), 1'b0, 1'b0},
			'{ctl(OP_TEXT, 8'h55), 1'b0, 1'b0},
			'{ctl(OP_FINISH, 8'h00), 1'b0, 1'b0},
			'{ctl(OP_START, 8'd3), 1'b0, 1'b0},
			'{ctl(OP_TEXT, 8'hFF), 1'b0, 1'b0},
			'{ctl(OP_FINISH, 8'h00), 1'b0, 1'b0}
		};
		foreach (dir_rows[r])
			offer(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);

		// every entry written before random starts can reach it
		for (int i = 0; i < NSTATES; i++)
			offer(rand_load(6'(i)), 1'b0, 1'b0);

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(1, 6))
					offer(rand_load(6'($urandom_range(NSTATES - 1))), 1'b0, 1'b0);
			if ($urandom_range(9) != 0)
				offer(ctl(OP_START, 8'($urandom_range(NSTATES - 1))), 1'b0, 1'b0);
			repeat ($urandom_range(0, 12))
				offer(ctl(OP_TEXT, text_byte()), 1'b0, 1'b0);
			offer(ctl(OP_FINISH, 8'h00), 1'b0, 1'b0);
			if ($urandom_range(9) == 0)
				offer(rand_bits(), 1'b0, 1'b0);
		end

		stim_done = 1'b1;
		s_tvalid <= 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("nfa_regex_simulator: match");
		else
			$display("nfa_regex_simulator: mismatch");
		$finish;
	end

	// result side: random backpressure plus one long hold-off
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				if (pending_matches.size() == 0)
					note_mismatch("result with none pending", 1'bx, m_tdata[0]);
				else if (m_tdata[0] !== pending_matches[0])
					note_mismatch("matched", pending_matches.pop_front(), m_tdata[0]);
				else
					void'(pending_matches.pop_front());
			end
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
				(m_tvalid === 1'b1 && m_tready === 1'b1) ||
				(stim_done && pending_matches.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("nfa_regex_simulator: mismatch");
			$finish;
		end
	end

endmodule

### nfa_regex_simulator.f
design/nfa_sim_pkg.sv
design/nfa_sim_ram.sv
design/nfa_regex_simulator.sv
test/testbench.sv
